>>> sv/pfe_pkg.sv
package pfe_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned TokenW  = 8;
  localparam int unsigned StatusW = 3;

  localparam logic [StatusW-1:0] StOk      = 3'd0;
  localparam logic [StatusW-1:0] StFull    = 3'd1;
  localparam logic [StatusW-1:0] StFew     = 3'd2;
  localparam logic [StatusW-1:0] StDivZero = 3'd3;
  localparam logic [StatusW-1:0] StUnknown = 3'd4;
  localparam logic [StatusW-1:0] StMany    = 3'd5;

  localparam logic [TokenW-1:0] ChZero  = 8'h30;
  localparam logic [TokenW-1:0] ChNine  = 8'h39;
  localparam logic [TokenW-1:0] ChPlus  = 8'h2B;
  localparam logic [TokenW-1:0] ChMinus = 8'h2D;
  localparam logic [TokenW-1:0] ChMul   = 8'h2A;
  localparam logic [TokenW-1:0] ChDiv   = 8'h2F;
  localparam logic [TokenW-1:0] ChMod   = 8'h25;
  localparam logic [TokenW-1:0] ChPow   = 8'h5E;

  typedef enum logic [2:0] {
    OpAdd,
    OpSub,
    OpMul,
    OpDiv,
    OpMod,
    OpPow
  } alu_op_e;

  typedef struct packed {
    logic    load;
    alu_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dp_sts_t;

endpackage

>>> sv/pfe_if.sv
interface pfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] token;
  logic       end_mark;
  modport source (output valid, token, end_mark, input ready);
  modport sink   (input valid, token, end_mark, output ready);
endinterface

interface pfe_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] value;
  modport source (output valid, status, value, input ready);
  modport sink   (input valid, status, value, output ready);
endinterface

>>> sv/pfe_ram.sv
module pfe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> sv/pfe_alu.sv
module pfe_alu (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pfe_pkg::dp_cmd_t       cmd_i,
  input  logic [31:0]            a_i,
  input  logic [31:0]            b_i,
  output pfe_pkg::dp_sts_t       sts_o,
  output logic [31:0]            res_o
);
  import pfe_pkg::*;

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  alu_op_e     op_q, op_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] aux_q, aux_d;
  logic [31:0] exp_q, exp_d;
  logic [31:0] rem_q, rem_d;
  logic        na_q, na_d, nb_q, nb_d;
  logic [31:0] res_q, res_d;
  logic [32:0] trial;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  assign ma = a_i[31] ? (32'd0 - a_i) : a_i;
  assign mb = b_i[31] ? (32'd0 - b_i) : b_i;
  assign trial = {rem_q, acc_q[31]} - {1'b0, aux_q};

  always_comb begin
    prod = 64'd0;
    if (cnt_q[0]) begin
      prod = aux_q * aux_q;
    end else begin
      prod = acc_q * aux_q;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    acc_d  = acc_q;
    aux_d  = aux_q;
    exp_d  = exp_q;
    rem_d  = rem_q;
    na_d   = na_q;
    nb_d   = nb_q;
    res_d  = res_q;
    if (cmd_i.load) begin
      op_d   = cmd_i.op;
      na_d   = a_i[31];
      nb_d   = b_i[31];
      cnt_d  = 6'd0;
      busy_d = 1'b1;
      rem_d  = 32'd0;
      exp_d  = b_i;
      unique case (cmd_i.op)
        OpAdd: begin res_d = a_i + b_i; busy_d = 1'b0; done_d = 1'b1; end
        OpSub: begin res_d = a_i - b_i; busy_d = 1'b0; done_d = 1'b1; end
        OpMul: begin acc_d = a_i; aux_d = b_i; end
        OpDiv, OpMod: begin acc_d = ma; aux_d = mb; end
        OpPow: begin
          if ($signed(b_i) < 32'sd2) begin
            res_d = a_i; busy_d = 1'b0; done_d = 1'b1;
          end else begin
            acc_d = 32'd1; aux_d = a_i;
          end
        end
        default: begin busy_d = 1'b0; done_d = 1'b1; end
      endcase
    end else if (busy_q) begin
      unique case (op_q)
        OpMul: begin
          res_d = prod[31:0]; busy_d = 1'b0; done_d = 1'b1;
        end
        OpDiv, OpMod: begin
          if (!trial[32]) begin
            rem_d = trial[31:0];
            acc_d = {acc_q[30:0], 1'b1};
          end else begin
            rem_d = {rem_q[30:0], acc_q[31]};
            acc_d = {acc_q[30:0], 1'b0};
          end
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            busy_d = 1'b0;
            done_d = 1'b1;
            if (op_q == OpMod) begin
              res_d = na_q ? (32'd0 - rem_d) : rem_d;
            end else begin
              res_d = (na_q != nb_q) ? (32'd0 - acc_d) : acc_d;
            end
          end
        end
        OpPow: begin
          // even phase: multiply in, odd phase: square and shift
          cnt_d = cnt_q + 6'd1;
          if (!cnt_q[0]) begin
            if (exp_q[0]) begin
              acc_d = prod[31:0];
            end
            if (exp_q[31:1] == 31'd0) begin
              res_d  = exp_q[0] ? prod[31:0] : acc_q;
              busy_d = 1'b0;
              done_d = 1'b1;
            end
          end else begin
            aux_d = prod[31:0];
            exp_d = {1'b0, exp_q[31:1]};
          end
        end
        default: begin busy_d = 1'b0; done_d = 1'b1; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
      op_q   <= OpAdd;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    aux_q <= aux_d;
    exp_q <= exp_d;
    rem_q <= rem_d;
    na_q  <= na_d;
    nb_q  <= nb_d;
    res_q <= res_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign res_o      = res_q;
endmodule

>>> sv/pfe_ctrl.sv
module pfe_ctrl #(
  parameter int unsigned StackDepth = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pfe_in_if.sink                        in_if,
  pfe_out_if.source                     out_if,
  output pfe_pkg::dp_cmd_t              cmd_o,
  input  pfe_pkg::dp_sts_t              sts_i,
  input  logic [31:0]                   alu_res_i,
  output logic                          we_o,
  output logic [$clog2(StackDepth)-1:0] waddr_o,
  output logic [31:0]                   wdata_o,
  output logic [$clog2(StackDepth)-1:0] raddr_o,
  input  logic [31:0]                   rdata_i,
  output logic [31:0]                   a_o,
  output logic [31:0]                   b_o
);
  import pfe_pkg::*;

  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned CW = $clog2(StackDepth + 1);
  localparam logic [CW-1:0] Full = CW'(StackDepth);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRdB  = 3'd1;
  localparam logic [2:0] SRdA  = 3'd2;
  localparam logic [2:0] SGetA = 3'd3;
  localparam logic [2:0] SExec = 3'd4;
  localparam logic [2:0] SWait = 3'd5;
  localparam logic [2:0] SEnd  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          disc_q, disc_d;
  logic [31:0]   held_q, held_d;
  logic [31:0]   b_q, b_d, a_q, a_d;
  alu_op_e       op_q, op_d;
  logic          ov_q, ov_d;
  logic [2:0]    ost_q, ost_d;
  logic [31:0]   oval_q, oval_d;
  logic [7:0]    tok;
  logic          is_op;
  alu_op_e       tok_op;

  assign tok = in_if.token;

  always_comb begin
    is_op  = 1'b1;
    tok_op = OpAdd;
    case (tok)
      ChPlus:  tok_op = OpAdd;
      ChMinus: tok_op = OpSub;
      ChMul:   tok_op = OpMul;
      ChDiv:   tok_op = OpDiv;
      ChMod:   tok_op = OpMod;
      ChPow:   tok_op = OpPow;
      default: is_op = 1'b0;
    endcase
  end

  assign in_if.ready = (state_q == SIdle) && !(ov_q && !out_if.ready);
  assign out_if.valid  = ov_q;
  assign out_if.status = ost_q;
  assign out_if.value  = oval_q;
  assign a_o = a_q;
  assign b_o = b_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    disc_d  = disc_q;
    held_d  = held_q;
    b_d     = b_q;
    a_d     = a_q;
    op_d    = op_q;
    ov_d    = ov_q && !out_if.ready;
    ost_d   = ost_q;
    oval_d  = oval_q;
    cmd_o.load = 1'b0;
    cmd_o.op   = op_q;
    we_o    = 1'b0;
    waddr_o = AW'(cnt_q);
    wdata_o = {24'd0, tok - ChZero};
    raddr_o = AW'(cnt_q - CW'(1));
    unique case (state_q)
      SIdle: begin
        if (in_if.valid && in_if.ready) begin
          if (in_if.end_mark) begin
            if (cnt_q == CW'(1) && !disc_q) begin
              state_d = SEnd;
            end else begin
              if (!disc_q) begin
                ov_d   = 1'b1;
                ost_d  = (cnt_q == '0) ? StOk : StMany;
                oval_d = (cnt_q == '0) ? held_q : 32'd0;
              end
              cnt_d  = '0;
              disc_d = 1'b0;
            end
          end else if (!disc_q) begin
            if (tok >= ChZero && tok <= ChNine) begin
              if (cnt_q >= Full) begin
                ov_d = 1'b1; ost_d = StFull; oval_d = 32'd0; disc_d = 1'b1;
              end else begin
                we_o  = 1'b1;
                cnt_d = cnt_q + CW'(1);
              end
            end else if (!is_op) begin
              ov_d = 1'b1; ost_d = StUnknown; oval_d = 32'd0; disc_d = 1'b1;
            end else if (cnt_q < CW'(2)) begin
              ov_d = 1'b1; ost_d = StFew; oval_d = 32'd0; disc_d = 1'b1;
            end else begin
              op_d    = tok_op;
              state_d = SRdB;
            end
          end
        end
      end
      SRdB: begin
        raddr_o = AW'(cnt_q - CW'(2));
        b_d     = rdata_i;
        state_d = SRdA;
      end
      SRdA: begin
        a_d     = rdata_i;
        state_d = SGetA;
      end
      SGetA: begin
        if ((op_q == OpDiv || op_q == OpMod) && b_q == 32'd0) begin
          ov_d = 1'b1; ost_d = StDivZero; oval_d = 32'd0; disc_d = 1'b1;
          state_d = SIdle;
        end else begin
          state_d = SExec;
        end
      end
      SExec: begin
        cmd_o.load = 1'b1;
        state_d    = SWait;
      end
      SWait: begin
        if (sts_i.done) begin
          we_o    = 1'b1;
          waddr_o = AW'(cnt_q - CW'(2));
          wdata_o = alu_res_i;
          cnt_d   = cnt_q - CW'(1);
          state_d = SIdle;
        end
      end
      SEnd: begin
        if (!ov_q) begin
          ov_d    = 1'b1;
          ost_d   = StOk;
          oval_d  = rdata_i;
          held_d  = rdata_i;
          cnt_d   = '0;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      disc_q  <= 1'b0;
      held_q  <= 32'd0;
      ov_q    <= 1'b0;
      op_q    <= OpAdd;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      disc_q  <= disc_d;
      held_q  <= held_d;
      ov_q    <= ov_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q    <= b_d;
    a_q    <= a_d;
    ost_q  <= ost_d;
    oval_q <= oval_d;
  end
endmodule

>>> sv/postfix_expression_evaluator_top.sv
// Postfix expression evaluator on a stack of 32-bit signed words.
// in_if carries one character token per word, or an end mark that closes
// the expression; out_if carries a status and a value, at most one word
// per input word. Digits push, operators pop two and push one.
// An error gives one word; later tokens are dropped until the end mark.
// An operator reads its two operands from the stack, then runs the ALU:
// + and - by an adder, * by the multiplier, / and % by the one-bit-a-cycle
// restoring divider, ^ by two multiplier passes per exponent bit.
// An end mark that leaves one value reads the stack top from RAM first.
// One word is worked on at a time; the stack RAM has one read port.
// Reset empties the stack, clears the drop flag and the held value.
// A result waits in the output register while the receiver stalls;
// the next word is taken once that register is free or being emptied.
module postfix_expression_evaluator_top #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  pfe_in_if.sink     in_if,
  pfe_out_if.source  out_if
);
  import pfe_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [31:0]   alu_res, a, b, wdata, rdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;

  pfe_ctrl #(.StackDepth(STACK_DEPTH)) u_ctrl (
    .clk_i, .rst_ni, .in_if, .out_if,
    .cmd_o(cmd), .sts_i(sts), .alu_res_i(alu_res),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .raddr_o(raddr), .rdata_i(rdata), .a_o(a), .b_o(b)
  );

  pfe_alu u_alu (
    .clk_i, .rst_ni, .cmd_i(cmd), .a_i(a), .b_i(b),
    .sts_o(sts), .res_o(alu_res)
  );

  pfe_ram #(.Width(32), .Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );
endmodule
